// ----- sv/pfe_pkg.sv -----
`timescale 1ns / 1ps
package pfe_pkg;

    // fixed port widths
    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 32;
    // width used to sign-extend values between port width and stack width
    localparam int EXT_W     = 64;

    // token queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_APPLY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WAIT,
        BK_DONE
    } back_state_t;

    // classified token as it travels through the queue
    typedef struct packed {
        logic                 is_push;
        op_t                  op;
        logic [OPERAND_W-1:0] value;
        logic                 last;
    } token_t;

    // request from the back end to the iterative mul/div unit
    typedef struct packed {
        logic start;
        logic is_div;
    } alu_req_t;

endpackage

// ----- sv/postfix_expression_evaluator.sv -----
`timescale 1ns / 1ps
// Postfix (RPN) evaluator. Each input word is one token: an operand push
// (s_cmd low) or an operator (s_cmd high, s_operator_code 0 add, 1 subtract,
// 2 multiply, 3 signed truncating divide). Arithmetic wraps at VALUE_WIDTH.
// Stack underflow, overflow and divide by zero latch a status and the rest
// of the expression is dropped. The word with s_last_token set returns one
// result word (top of stack, or 0 when status is nonzero) and clears the
// stack. A two-word token queue decouples the input from the execution
// engine. A push or an ignored token retires from the idle state, add and
// subtract pass through one stack memory read, and multiply and divide
// also wait on the bit-serial shift-add / restoring divide unit; a last
// token then passes through a done state that loads the result register.
module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic signed [OPERAND_W-1:0] s_operand_value,
    input  logic [1:0]                  s_operator_code,
    input  logic                        s_last_token,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [RESULT_W-1:0]  m_result_value,
    output logic [1:0]                  m_status
);

    logic                   q_full;
    logic                   q_push;
    token_t                 q_in_token;
    logic                   q_valid;
    logic                   q_pop;
    token_t                 q_out_token;
    alu_req_t               alu_req;
    logic [VALUE_WIDTH-1:0] alu_lhs;
    logic [VALUE_WIDTH-1:0] alu_rhs;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;
    logic [RESULT_W-1:0]    result_value;

    pfe_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_operand_value (s_operand_value),
        .s_operator_code (s_operator_code),
        .s_last_token    (s_last_token),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_token         (q_in_token)
    );

    pfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (q_in_token),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .pop_token  (q_out_token)
    );

    pfe_alu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .lhs     (alu_lhs),
        .rhs     (alu_rhs),
        .done    (alu_done),
        .result  (alu_result)
    );

    pfe_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_token        (q_out_token),
        .q_pop          (q_pop),
        .alu_req        (alu_req),
        .alu_lhs        (alu_lhs),
        .alu_rhs        (alu_rhs),
        .alu_done       (alu_done),
        .alu_result     (alu_result),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (result_value),
        .m_status       (m_status)
    );

    assign m_result_value = signed'(result_value);

endmodule

// ----- sv/pfe_front.sv -----
`timescale 1ns / 1ps
module pfe_front
    import pfe_pkg::*;
(
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [OPERAND_W-1:0] s_operand_value,
    input  logic [1:0]           s_operator_code,
    input  logic                 s_last_token,
    input  logic                 q_full,
    output logic                 q_push,
    output token_t               q_token
);

    // accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // classify the incoming word
    always_comb begin
        q_token.is_push = (cmd_t'(s_cmd) == CMD_PUSH);
        q_token.op      = op_t'(s_operator_code);
        q_token.value   = s_operand_value;
        q_token.last    = s_last_token;
    end

endmodule

// ----- sv/pfe_queue.sv -----
`timescale 1ns / 1ps
module pfe_queue
    import pfe_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  token_t push_token,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output token_t pop_token
);

    token_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg,  count_next;

    assign full      = (count_reg == Q_CW'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_token = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

// ----- sv/pfe_alu.sv -----
`timescale 1ns / 1ps
module pfe_alu
    import pfe_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  alu_req_t               req,
    input  logic [VALUE_WIDTH-1:0] lhs,
    input  logic [VALUE_WIDTH-1:0] rhs,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   is_div_reg, is_div_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    // product for mul, partial remainder for div
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    // multiplier for mul, dividend shifting into quotient for div
    logic [VALUE_WIDTH-1:0] sh_reg, sh_next;
    // multiplicand for mul, divisor magnitude for div
    logic [VALUE_WIDTH-1:0] dv_reg, dv_next;

    logic [VALUE_WIDTH-1:0] abs_lhs, abs_rhs;
    logic [VALUE_WIDTH:0]   trial, diff;

    assign abs_lhs = lhs[VALUE_WIDTH-1] ? (~lhs + 1'b1) : lhs;
    assign abs_rhs = rhs[VALUE_WIDTH-1] ? (~rhs + 1'b1) : rhs;

    // restoring divide step
    assign trial = {acc_reg, sh_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dv_reg};

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        dv_next     = dv_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            is_div_next = req.is_div;
            cnt_next    = '0;
            acc_next    = '0;
            if (req.is_div) begin
                neg_next = lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
                sh_next  = abs_lhs;
                dv_next  = abs_rhs;
            end else begin
                neg_next = 1'b0;
                sh_next  = rhs;
                dv_next  = lhs;
            end
        end else if (busy_reg) begin
            if (is_div_reg) begin
                if (!diff[VALUE_WIDTH]) begin
                    acc_next = diff[VALUE_WIDTH-1:0];
                    sh_next  = {sh_reg[VALUE_WIDTH-2:0], 1'b1};
                end else begin
                    acc_next = trial[VALUE_WIDTH-1:0];
                    sh_next  = {sh_reg[VALUE_WIDTH-2:0], 1'b0};
                end
            end else begin
                // shift-and-add, low half of the product kept
                if (sh_reg[0]) begin
                    acc_next = acc_reg + dv_reg;
                end
                dv_next = {dv_reg[VALUE_WIDTH-2:0], 1'b0};
                sh_next = {1'b0, sh_reg[VALUE_WIDTH-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        dv_reg     <= dv_next;
    end

    assign done   = done_reg;
    // quotient sign fixup; min / -1 wraps back to min
    assign result = is_div_reg ? (neg_reg ? (~sh_reg + 1'b1) : sh_reg) : acc_reg;

endmodule

// ----- sv/pfe_back.sv -----
`timescale 1ns / 1ps
module pfe_back
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // token queue
    input  logic                   q_valid,
    input  token_t                 q_token,
    output logic                   q_pop,
    // mul/div unit
    output alu_req_t               alu_req,
    output logic [VALUE_WIDTH-1:0] alu_lhs,
    output logic [VALUE_WIDTH-1:0] alu_rhs,
    input  logic                   alu_done,
    input  logic [VALUE_WIDTH-1:0] alu_result,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [RESULT_W-1:0]    m_result_value,
    output logic [1:0]             m_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // entries below the top of stack; the top lives in top_reg
    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    back_state_t            state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    status_t                sticky_reg, sticky_next;
    logic [VALUE_WIDTH-1:0] top_reg, top_next;
    op_t                    op_reg, op_next;
    logic                   last_reg, last_next;

    logic                   m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0]    result_reg, result_next;
    status_t                status_reg, status_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    logic [CW-1:0]          cnt_m1, cnt_m2;
    logic [EXT_W-1:0]       push_ext, top_ext;
    logic [VALUE_WIDTH-1:0] push_val;
    status_t                fin_status;
    logic                   out_free;

    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign push_ext = EXT_W'(signed'(q_token.value));
    assign push_val = push_ext[VALUE_WIDTH-1:0];
    assign top_ext  = EXT_W'(signed'(top_reg));
    assign out_free = !m_valid_reg || m_ready;

    assign alu_lhs  = rd_data_reg;
    assign alu_rhs  = top_reg;

    // status reported for the finished expression
    always_comb begin
        if (sticky_reg != ST_OK) begin
            fin_status = sticky_reg;
        end else if (count_reg == '0) begin
            fin_status = ST_UNDER;
        end else begin
            fin_status = ST_OK;
        end
    end

    // sequencer: next state, stack update, memory and unit control
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        sticky_next    = sticky_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        result_next    = result_reg;
        status_next    = status_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cnt_m1[AW-1:0];
        mem_re         = 1'b0;
        mem_raddr      = cnt_m2[AW-1:0];
        alu_req.start  = 1'b0;
        alu_req.is_div = (op_reg == OP_DIV);

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    last_next  = q_token.last;
                    state_next = q_token.last ? BK_DONE : BK_IDLE;
                    if (sticky_reg != ST_OK) begin
                        // error pending: token dropped
                    end else if (q_token.is_push) begin
                        if (count_reg == CW'(STACK_DEPTH)) begin
                            sticky_next = ST_OVER;
                        end else begin
                            // spill old top below the new one
                            mem_we     = (count_reg != '0);
                            top_next   = push_val;
                            count_next = count_reg + CW'(1);
                        end
                    end else if (count_reg < CW'(2)) begin
                        sticky_next = ST_UNDER;
                    end else begin
                        mem_re     = 1'b1;
                        op_next    = q_token.op;
                        state_next = BK_READ;
                    end
                end
            end

            BK_READ: begin
                state_next = last_reg ? BK_DONE : BK_IDLE;
                unique case (op_reg)
                    OP_ADD: begin
                        top_next   = rd_data_reg + top_reg;
                        count_next = cnt_m1;
                    end
                    OP_SUB: begin
                        top_next   = rd_data_reg - top_reg;
                        count_next = cnt_m1;
                    end
                    OP_MUL: begin
                        alu_req.start = 1'b1;
                        state_next    = BK_WAIT;
                    end
                    OP_DIV: begin
                        if (top_reg == '0) begin
                            // both operands stay popped
                            sticky_next = ST_DIVZ;
                            count_next  = cnt_m2;
                        end else begin
                            alu_req.start = 1'b1;
                            state_next    = BK_WAIT;
                        end
                    end
                    default: begin
                        state_next = BK_IDLE;
                    end
                endcase
            end

            BK_WAIT: begin
                if (alu_done) begin
                    top_next   = alu_result;
                    count_next = cnt_m1;
                    state_next = last_reg ? BK_DONE : BK_IDLE;
                end
            end

            BK_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    status_next  = fin_status;
                    result_next  = (fin_status == ST_OK) ? top_ext[RESULT_W-1:0] : '0;
                    count_next   = '0;
                    sticky_next  = ST_OK;
                    state_next   = BK_IDLE;
                end
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sticky_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // operand stack storage, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= top_reg;
        end
        if (mem_re) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = result_reg;
    assign m_status       = status_reg;

endmodule
